// File: rtl/rotation_matrix_to_quaternion_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion core
// Shared property forms used by the checker of the core.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RMQ_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rmq assertion failed");

// Next-cycle implication, off during reset.
`define RMQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

// Next-cycle implication that also covers reset itself.
`define RMQ_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

`endif

// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and codes of the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

  typedef logic [1:0] pivot_t;

  localparam pivot_t PIV_TRACE = 2'd0;
  localparam pivot_t PIV_X     = 2'd1;
  localparam pivot_t PIV_Y     = 2'd2;
  localparam pivot_t PIV_Z     = 2'd3;

endpackage

// File: rtl/rmq_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
  parameter int RAD_W = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RAD_W-1:0]     rad,
  output logic [RAD_W/2-1:0]   root
);
  import rmq_pkg::*;

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [1:ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [1:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [1:ROOT_W];

  genvar k;
  for (k = 1; k <= ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_src;
    logic [ROOT_W-1:0] root_src;
    logic [RAD_W-1:0]  rad_src;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              hit;

    if (k == 1) begin : g_first
      assign rem_src  = '0;
      assign root_src = '0;
      assign rad_src  = rad;
    end else begin : g_next
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign rad_src  = rad_q[k-1];
    end

    // bring down the next two radicand bits and try (root*4 + 1)
    assign rem_sh = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_src, 2'b01};
    assign hit    = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_src[ROOT_W-2:0], hit};
      end
    end

    if (k < ROOT_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= hit ? (rem_sh - trial) : rem_sh;
          rad_q[k] <= {rad_src[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[ROOT_W];

endmodule

// File: rtl/rmq_div_pipe.sv
// ----------------------------------------------------------------------------
// rmq_div_pipe
// Pipelined restoring divider with quotient overflow flag, one bit per stage.
// ----------------------------------------------------------------------------
module rmq_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17,
  parameter int Q_W   = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [Q_W-1:0]    quo,
  output logic              ovf
);
  import rmq_pkg::*;

  localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [CW-1:0]    rem_q [0:Q_W-1];
  logic [DEN_W-1:0] den_q [0:Q_W-1];
  logic             ovf_q [0:Q_W];
  logic [Q_W-1:0]   quo_q [1:Q_W];

  // flag quotients that do not fit in Q_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= CW'(num);
      den_q[0] <= den;
      ovf_q[0] <= (CW'(num) >= (CW'(den) << Q_W));
    end
  end

  genvar k;
  for (k = 1; k <= Q_W; k++) begin : g_stage
    localparam int B = Q_W - k;
    logic [Q_W-1:0] quo_src;
    logic [Q_W-1:0] quo_next;
    logic [CW-1:0]  trial;
    logic           hit;

    if (k == 1) begin : g_first
      assign quo_src = '0;
    end else begin : g_next
      assign quo_src = quo_q[k-1];
    end

    assign trial = CW'(den_q[k-1]) << B;
    assign hit   = (rem_q[k-1] >= trial);

    always_comb begin
      quo_next    = quo_src;
      quo_next[B] = hit;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k] <= quo_next;
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= hit ? (rem_q[k-1] - trial) : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo = quo_q[Q_W];
  assign ovf = ovf_q[Q_W];

endmodule

// File: rtl/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Rotation matrix to unit quaternion (Shepperd's method), fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Matrix channel: matrix_valid / matrix_stall carry m00..m22, signed with
//   FRAC_BITS fraction bits. A beat moves when valid is high and stall low.
//   Quaternion channel: quat_valid / quat_stall carry qw, qx, qy, qz
//   (saturated), pivot (trace or x/y/z axis) and degenerate (components
//   forced to zero when the square root argument is not positive).
//   Throughput: one beat per cycle while the output is not stalled.
//   Path: stages 1 and 2, then the bit-per-stage square root pipe, stage 3,
//   the bit-per-stage divider pipes (one per off-pivot component) and the
//   output register.
//   Stall: the whole pipeline holds while a finished beat waits at the
//   output; matrix_stall follows at once, so no beat is lost or repeated.
//   Reset: synchronous, active high; clears all valid bits, so the pipe
//   comes up empty and accepts a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS  = 14,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         matrix_valid,
  output logic                         matrix_stall,
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m01,
  input  logic signed [DATA_WIDTH-1:0] m02,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m11,
  input  logic signed [DATA_WIDTH-1:0] m12,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic                         quat_valid,
  input  logic                         quat_stall,
  output logic signed [DATA_WIDTH-1:0] qw,
  output logic signed [DATA_WIDTH-1:0] qx,
  output logic signed [DATA_WIDTH-1:0] qy,
  output logic signed [DATA_WIDTH-1:0] qz,
  output rmq_pkg::pivot_t              pivot,
  output logic                         degenerate
);
  import rmq_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  // signed width of every square root argument candidate
  localparam int AW  = ((W + 2 > F + 2) ? W + 2 : F + 2) + 1;
  // radicand arg << F, rounded up to an even width
  localparam int RW  = AW - 1 + F;
  localparam int RWE = RW + (RW % 2);
  localparam int SB  = RWE / 2;
  localparam int TW  = W + 1;           // off-pivot sums and differences
  localparam int NW  = W + F + 2;       // divider numerator
  localparam int DVW = SB + 1;          // divider denominator 2*s
  localparam int DL  = W + 1;           // divider latency
  localparam int CMW = ((SB > W) ? SB : W) + 1;

  // whole pipe advances unless a finished beat is held at the output
  logic en;
  assign en           = !(quat_valid && quat_stall);
  assign matrix_stall = !en;

  // --------------------------------------------------------------------------
  // Stage 1: trace, diagonal compare, all argument candidates and terms
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] one_a;
  assign one_a = {{(AW-1){1'b0}}, 1'b1} << F;

  logic                 s1_v;
  logic                 s1_tpos;
  logic [1:0]           s1_ax;
  logic signed [AW-1:0] s1_argt, s1_arg0, s1_arg1, s1_arg2;
  logic signed [TW-1:0] s1_d21, s1_d02, s1_d10, s1_s10, s1_s20, s1_s21;

  logic signed [AW-1:0] tr;
  logic [1:0]           ax;
  logic signed [W-1:0]  dii;

  always_comb begin
    tr = AW'(m00) + AW'(m11) + AW'(m22);
    // strict compares: the lower axis wins a tie
    ax  = 2'd0;
    dii = m00;
    if (m11 > m00) begin
      ax  = 2'd1;
      dii = m11;
    end
    if (m22 > dii) begin
      ax = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= matrix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tpos <= (tr > 0);
      s1_ax   <= ax;
      s1_argt <= tr + one_a;
      s1_arg0 <= AW'(m00) - AW'(m11) - AW'(m22) + one_a;
      s1_arg1 <= AW'(m11) - AW'(m22) - AW'(m00) + one_a;
      s1_arg2 <= AW'(m22) - AW'(m00) - AW'(m11) + one_a;
      s1_d21  <= TW'(m21) - TW'(m12);
      s1_d02  <= TW'(m02) - TW'(m20);
      s1_d10  <= TW'(m10) - TW'(m01);
      s1_s10  <= TW'(m10) + TW'(m01);
      s1_s20  <= TW'(m20) + TW'(m02);
      s1_s21  <= TW'(m21) + TW'(m12);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick the branch, its argument and the three off-pivot terms.
  // Terms ta, tb, tc go to the non-pivot slots in w, x, y, z order.
  // --------------------------------------------------------------------------
  logic                 s2_v;
  pivot_t               s2_piv;
  logic                 s2_degen;
  logic [RWE-1:0]       s2_rad;
  logic signed [TW-1:0] s2_ta, s2_tb, s2_tc;

  pivot_t               piv_c;
  logic signed [AW-1:0] arg_c;
  logic signed [TW-1:0] ta_c, tb_c, tc_c;
  logic                 degen_c;

  always_comb begin
    if (s1_tpos) begin
      piv_c = PIV_TRACE;
    end else begin
      case (s1_ax)
        2'd0:    piv_c = PIV_X;
        2'd1:    piv_c = PIV_Y;
        default: piv_c = PIV_Z;
      endcase
    end
    case (piv_c)
      PIV_TRACE: begin
        arg_c = s1_argt; ta_c = s1_d21; tb_c = s1_d02; tc_c = s1_d10;
      end
      PIV_X: begin
        arg_c = s1_arg0; ta_c = s1_d21; tb_c = s1_s10; tc_c = s1_s20;
      end
      PIV_Y: begin
        arg_c = s1_arg1; ta_c = s1_d02; tb_c = s1_s10; tc_c = s1_s21;
      end
      default: begin
        arg_c = s1_arg2; ta_c = s1_d10; tb_c = s1_s20; tc_c = s1_s21;
      end
    endcase
    degen_c = arg_c[AW-1] || (arg_c == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_piv   <= piv_c;
      s2_degen <= degen_c;
      s2_rad   <= degen_c ? '0 : ({{(RWE-AW+1){1'b0}}, arg_c[AW-2:0]} << F);
      s2_ta    <= ta_c;
      s2_tb    <= tb_c;
      s2_tc    <= tc_c;
    end
  end

  // --------------------------------------------------------------------------
  // Square root pipe, sideband rides alongside
  // --------------------------------------------------------------------------
  logic [SB-1:0] root;

  rmq_sqrt_pipe #(
    .RAD_W (RWE)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s2_rad),
    .root (root)
  );

  logic                 sq_v     [1:SB];
  pivot_t               sq_piv   [1:SB];
  logic                 sq_degen [1:SB];
  logic signed [TW-1:0] sq_ta    [1:SB];
  logic signed [TW-1:0] sq_tb    [1:SB];
  logic signed [TW-1:0] sq_tc    [1:SB];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= SB; i++) begin
        sq_v[i] <= 1'b0;
      end
    end else if (en) begin
      sq_v[1] <= s2_v;
      for (int i = 2; i <= SB; i++) begin
        sq_v[i] <= sq_v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_piv[1]   <= s2_piv;
      sq_degen[1] <= s2_degen;
      sq_ta[1]    <= s2_ta;
      sq_tb[1]    <= s2_tb;
      sq_tc[1]    <= s2_tc;
      for (int i = 2; i <= SB; i++) begin
        sq_piv[i]   <= sq_piv[i-1];
        sq_degen[i] <= sq_degen[i-1];
        sq_ta[i]    <= sq_ta[i-1];
        sq_tb[i]    <= sq_tb[i-1];
        sq_tc[i]    <= sq_tc[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: s/2 rounded, term magnitudes, rounded numerators
  // --------------------------------------------------------------------------
  logic           s3_v;
  pivot_t         s3_piv;
  logic           s3_degen;
  logic [SB-1:0]  s3_half;
  logic [2:0]     s3_neg;
  logic [NW-1:0]  s3_num [0:2];
  logic [DVW-1:0] s3_den;

  logic [SB:0]    root_p1;
  logic [TW-1:0]  mag_c [0:2];
  logic [2:0]     neg_c;

  always_comb begin
    root_p1  = (SB+1)'(root) + (SB+1)'(1);
    neg_c[0] = sq_ta[SB][TW-1];
    neg_c[1] = sq_tb[SB][TW-1];
    neg_c[2] = sq_tc[SB][TW-1];
    mag_c[0] = neg_c[0] ? TW'(-sq_ta[SB]) : TW'(sq_ta[SB]);
    mag_c[1] = neg_c[1] ? TW'(-sq_tb[SB]) : TW'(sq_tb[SB]);
    mag_c[2] = neg_c[2] ? TW'(-sq_tc[SB]) : TW'(sq_tc[SB]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= sq_v[SB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_piv   <= sq_piv[SB];
      s3_degen <= sq_degen[SB] || (root == '0);
      s3_half  <= root_p1[SB:1];
      s3_neg   <= neg_c;
      s3_den   <= {root, 1'b0};
      for (int i = 0; i < 3; i++) begin
        s3_num[i] <= NW'({mag_c[i], {F{1'b0}}}) + NW'(root);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipes, one per off-pivot component
  // --------------------------------------------------------------------------
  logic [W-1:0] quo [0:2];
  logic [2:0]   ovf;

  genvar g;
  for (g = 0; g < 3; g++) begin : g_div
    rmq_div_pipe #(
      .NUM_W (NW),
      .DEN_W (DVW),
      .Q_W   (W)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (s3_num[g]),
      .den (s3_den),
      .quo (quo[g]),
      .ovf (ovf[g])
    );
  end

  logic          dv_v     [1:DL];
  pivot_t        dv_piv   [1:DL];
  logic          dv_degen [1:DL];
  logic [SB-1:0] dv_half  [1:DL];
  logic [2:0]    dv_neg   [1:DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DL; i++) begin
        dv_v[i] <= 1'b0;
      end
    end else if (en) begin
      dv_v[1] <= s3_v;
      for (int i = 2; i <= DL; i++) begin
        dv_v[i] <= dv_v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_piv[1]   <= s3_piv;
      dv_degen[1] <= s3_degen;
      dv_half[1]  <= s3_half;
      dv_neg[1]   <= s3_neg;
      for (int i = 2; i <= DL; i++) begin
        dv_piv[i]   <= dv_piv[i-1];
        dv_degen[i] <= dv_degen[i-1];
        dv_half[i]  <= dv_half[i-1];
        dv_neg[i]   <= dv_neg[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturate, route by pivot, hold on stall
  // --------------------------------------------------------------------------
  logic signed [W-1:0] smax_s;
  logic [W-1:0]        smax_u;
  assign smax_u = {1'b0, {(W-1){1'b1}}};
  assign smax_s = {1'b0, {(W-1){1'b1}}};

  function automatic logic signed [W-1:0] sat_term(
    input logic         neg,
    input logic [W-1:0] q,
    input logic         of
  );
    logic signed [W-1:0] r;
    logic                big;
    big = q[W-1] && (|q[W-2:0]);
    if (of) begin
      r = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (neg) begin
      r = big ? {1'b1, {(W-1){1'b0}}} : -$signed(q);
    end else begin
      r = q[W-1] ? {1'b0, {(W-1){1'b1}}} : $signed(q);
    end
    return r;
  endfunction

  logic signed [W-1:0] hs, ra, rb, rc;
  logic signed [W-1:0] w_c, x_c, y_c, z_c;

  always_comb begin
    hs = (CMW'(dv_half[DL]) > CMW'(smax_u)) ? smax_s : W'(dv_half[DL]);
    ra = sat_term(dv_neg[DL][0], quo[0], ovf[0]);
    rb = sat_term(dv_neg[DL][1], quo[1], ovf[1]);
    rc = sat_term(dv_neg[DL][2], quo[2], ovf[2]);
    case (dv_piv[DL])
      PIV_TRACE: begin w_c = hs; x_c = ra; y_c = rb; z_c = rc; end
      PIV_X:     begin w_c = ra; x_c = hs; y_c = rb; z_c = rc; end
      PIV_Y:     begin w_c = ra; x_c = rb; y_c = hs; z_c = rc; end
      default:   begin w_c = ra; x_c = rb; y_c = rc; z_c = hs; end
    endcase
    // drop all components of a degenerate beat
    if (dv_degen[DL]) begin
      w_c = '0;
      x_c = '0;
      y_c = '0;
      z_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (en) begin
      quat_valid <= dv_v[DL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw         <= w_c;
      qx         <= x_c;
      qy         <= y_c;
      qz         <= z_c;
      pivot      <= dv_piv[DL];
      degenerate <= dv_degen[DL];
    end
  end

endmodule

// File: rtl/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_core_defines.svh"

module rmq_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         quat_valid,
  input logic                         quat_stall,
  input logic signed [DATA_WIDTH-1:0] qw,
  input logic signed [DATA_WIDTH-1:0] qx,
  input logic signed [DATA_WIDTH-1:0] qy,
  input logic signed [DATA_WIDTH-1:0] qz,
  input rmq_pkg::pivot_t              pivot,
  input logic                         degenerate
);
  import rmq_pkg::*;

  logic                      comps_zero;
  logic                      piv_pos;
  logic [4*DATA_WIDTH+2:0]   beat;

  assign comps_zero = (qw == '0) && (qx == '0) && (qy == '0) && (qz == '0);
  assign piv_pos    = (pivot == PIV_TRACE && qw > 0) || (pivot == PIV_X && qx > 0) ||
                      (pivot == PIV_Y && qy > 0) || (pivot == PIV_Z && qz > 0);
  assign beat       = {qw, qx, qy, qz, pivot, degenerate};

  // a degenerate beat carries all-zero components
  `RMQ_ASSERT_IMPLY(a_degen_zero, clk, rst, quat_valid && degenerate, comps_zero)

  // the pivot component is the rounded s/2 and so strictly positive
  `RMQ_ASSERT_IMPLY(a_pivot_positive, clk, rst, quat_valid && !degenerate, piv_pos)

  // a stalled beat holds
  `RMQ_ASSERT_NEXT(a_stall_hold, clk, rst, quat_valid && quat_stall, quat_valid && $stable(beat))

  // the pipe comes out of reset empty
  `RMQ_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !quat_valid)

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (.*);
